// ----- rtl/skset_pkg.sv -----
// Shared constants, types and result word layout for the sorted key set.
package skset_pkg;

    // Number of keys the set can hold.
    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    typedef logic [AW-1:0]           addr_t;
    typedef logic [CW-1:0]           count_t;
    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_LIST   = 2'd3
    } mode_e;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_LIST = 2'd3
    } status_e;

    // One result word as it travels from the sequencer to the output stage.
    typedef struct packed {
        status_e status;
        logic    found;
        key_t    key_out;
        logic    set_empty;
        logic    last;
    } res_t;

endpackage

// ----- rtl/sorted_key_set.sv -----
// Sorted key set: holds up to CAPACITY distinct signed keys in ascending order in a
// memory with one write port and one read port with registered read data. Every operation
// walks that memory one entry per cycle, a list only while the output register is free.
// Search walks up to the first held key not below the searched one. Insert walks up to
// the key, shifts the entries above it up by one, top first, then writes the new key.
// Remove walks up to the key, then shifts the entries above it down by one. List emits
// one word per cycle while the output register is free.
// The memory needs no clearing after reset; the entry count alone says which entries
// hold keys. A finished word waits in an output register, so a new input word is taken
// as soon as the sequencer is back in idle, even while the last result is not yet taken.
module sorted_key_set
    import skset_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic signed [31:0] key,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic              found,
    output logic signed [31:0] key_out,
    output logic              set_empty,
    output logic              last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DOWN,
        S_LIST
    } state_t;

    state_t state_reg, state_next;
    addr_t  ptr_reg, ptr_next;
    addr_t  pos_reg, pos_next;
    count_t count_reg, count_next;
    mode_e  mode_reg, mode_next;
    key_t   key_reg, key_next;

    logic   ram_we;
    addr_t  ram_waddr;
    key_t   ram_wdata;
    addr_t  ram_raddr;
    key_t   rdata;

    logic   push;
    res_t   push_res;
    logic   ob_free;
    res_t   res;

    addr_t  ptr_inc, ptr_dec, cnt_m1_addr;
    count_t idx_inc, cnt_m1, cnt_p1;
    logic   hit, held, tail, scan_end, is_full;

    function automatic res_t make_res(status_e st, logic fnd, key_t k, logic emp, logic lst);
        res_t r;
        r.status    = st;
        r.found     = fnd;
        r.key_out   = k;
        r.set_empty = emp;
        r.last      = lst;
        return r;
    endfunction

    skset_ram #(
        .DW (KEY_W),
        .AW (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    skset_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .free      (ob_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // Pointer arithmetic and the compare on the entry currently read.
    assign ptr_inc     = ptr_reg + addr_t'(1);
    assign ptr_dec     = ptr_reg - addr_t'(1);
    assign idx_inc     = count_t'(ptr_reg) + count_t'(1);
    assign cnt_m1      = count_reg - count_t'(1);
    assign cnt_p1      = count_reg + count_t'(1);
    assign cnt_m1_addr = cnt_m1[AW-1:0];
    assign tail        = (idx_inc == count_reg);
    assign hit         = (count_reg != '0) && !(rdata < key_reg);
    assign held        = hit && (rdata == key_reg);
    assign scan_end    = (count_reg == '0) || hit || tail;
    assign is_full     = (count_reg >= count_t'(CAPACITY));

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer: walks the memory and decides each step.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = rdata;
        ram_raddr  = ptr_reg;
        push       = 1'b0;
        push_res   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (in_valid)
                begin
                    mode_next = mode_e'(mode);
                    key_next  = key;
                    ptr_next  = '0;
                    if (mode_e'(mode) == MODE_LIST)
                    begin
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (!scan_end)
                begin
                    ptr_next  = ptr_inc;
                    ram_raddr = ptr_inc;
                end
                else
                begin
                    unique case (mode_reg)
                        MODE_SEARCH:
                        begin
                            if (ob_free)
                            begin
                                push       = 1'b1;
                                push_res   = make_res(held ? ST_DONE : ST_MISS, held,
                                                      '0, 1'b0, 1'b1);
                                state_next = S_IDLE;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (held || is_full)
                            begin
                                if (ob_free)
                                begin
                                    push       = 1'b1;
                                    push_res   = make_res(held ? ST_MISS : ST_FULL, 1'b0,
                                                          '0, 1'b0, 1'b1);
                                    state_next = S_IDLE;
                                end
                            end
                            else if (hit)
                            begin
                                // Larger keys move up one place, top first.
                                pos_next   = ptr_reg;
                                ptr_next   = cnt_m1_addr;
                                ram_raddr  = cnt_m1_addr;
                                state_next = S_SHIFT_UP;
                            end
                            else
                            begin
                                pos_next   = count_reg[AW-1:0];
                                state_next = S_PLACE;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (!held)
                            begin
                                if (ob_free)
                                begin
                                    push       = 1'b1;
                                    push_res   = make_res(ST_MISS, 1'b0, '0, 1'b0, 1'b1);
                                    state_next = S_IDLE;
                                end
                            end
                            else if (tail)
                            begin
                                // The top entry goes: only the count drops.
                                if (ob_free)
                                begin
                                    count_next = cnt_m1;
                                    push       = 1'b1;
                                    push_res   = make_res(ST_DONE, 1'b0, '0, 1'b0, 1'b1);
                                    state_next = S_IDLE;
                                end
                            end
                            else
                            begin
                                pos_next   = ptr_reg;
                                ptr_next   = ptr_inc;
                                ram_raddr  = ptr_inc;
                                state_next = S_SHIFT_DOWN;
                            end
                        end
                        MODE_LIST:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SHIFT_UP:
            begin
                // Entry at ptr moves to ptr + 1 while the one below is read.
                ram_we    = 1'b1;
                ram_waddr = ptr_inc;
                ram_wdata = rdata;
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ptr_next  = ptr_dec;
                    ram_raddr = ptr_dec;
                end
            end

            S_PLACE:
            begin
                if (ob_free)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = key_reg;
                    count_next = cnt_p1;
                    push       = 1'b1;
                    push_res   = make_res(ST_DONE, 1'b0, '0, 1'b0, 1'b1);
                    state_next = S_IDLE;
                end
            end

            S_SHIFT_DOWN:
            begin
                // Entry at ptr moves to ptr - 1 while the one above is read.
                if (tail)
                begin
                    if (ob_free)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = ptr_dec;
                        ram_wdata  = rdata;
                        count_next = cnt_m1;
                        push       = 1'b1;
                        push_res   = make_res(ST_DONE, 1'b0, '0, 1'b0, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_dec;
                    ram_wdata = rdata;
                    ptr_next  = ptr_inc;
                    ram_raddr = ptr_inc;
                end
            end

            S_LIST:
            begin
                if (count_reg == '0)
                begin
                    if (ob_free)
                    begin
                        push       = 1'b1;
                        push_res   = make_res(ST_DONE, 1'b0, '0, 1'b1, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else if (ob_free)
                begin
                    push     = 1'b1;
                    push_res = make_res(ST_LIST, 1'b0, rdata, 1'b0, tail);
                    if (tail)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next  = ptr_inc;
                        ram_raddr = ptr_inc;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            mode_reg  <= MODE_INSERT;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            mode_reg  <= mode_next;
            key_reg   <= key_next;
        end
    end

    // Result word fields.
    assign status    = res.status;
    assign found     = res.found;
    assign key_out   = res.key_out;
    assign set_empty = res.set_empty;
    assign last      = res.last;

endmodule

// ----- rtl/skset_ram.sv -----
// Simple dual-port key store: one write port, one read port with registered data.
module skset_ram #(
    parameter int DW = 32,
    parameter int AW = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/skset_obuf.sv -----
// Output register that holds one result word until the consumer takes it.
module skset_obuf
    import skset_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  res_t        push_res,
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        res
);

    logic valid_reg;
    res_t res_reg;

    // A new word may enter when the register is empty or is being drained.
    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for sorted_key_set: directed and random words checked against a behavioral set model.
module tb_top
    import skset_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int POOL_SIZE    = 40;
    localparam int RANDOM_WORDS = 17;

    // One input word waiting in the driver queue.
    typedef struct {
        mode_e mode;
        key_t  key;
        bit    drain_first;
    } cmd_word_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         mode      = 2'd0;
    logic signed [31:0] key       = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] key_out;
    logic               set_empty;
    logic               last;

    // Behavioral copy of the set and the queues around it.
    key_t      held_keys [CAPACITY];
    int        held_count  = 0;
    res_t      expected_results[$];
    cmd_word_t pending_words[$];
    key_t      key_pool [POOL_SIZE];
    int        words_sent  = 0;
    int        words_taken = 0;
    int        total_words = 0;
    int        error_count = 0;
    int        cycle_count = 0;

    sorted_key_set dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .found     (found),
        .key_out   (key_out),
        .set_empty (set_empty),
        .last      (last)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Update the set copy for one accepted word and queue the result words it causes.
    task automatic apply_word(input mode_e m, input key_t k);
        int   pos;
        bit   held;
        res_t r;
        pos = 0;
        while (pos < held_count && held_keys[pos] < k)
            pos++;
        held = (pos < held_count) && (held_keys[pos] == k);
        r = '0;
        r.last = 1'b1;
        case (m)
            MODE_LIST:
            begin
                if (held_count == 0)
                begin
                    r.set_empty = 1'b1;
                    expected_results.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        r.status  = ST_LIST;
                        r.key_out = held_keys[i];
                        r.last    = (i == held_count - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            MODE_INSERT:
            begin
                if (held)
                    r.status = ST_MISS;
                else if (held_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = held_count; i > pos; i--)
                        held_keys[i] = held_keys[i - 1];
                    held_keys[pos] = k;
                    held_count++;
                end
                expected_results.push_back(r);
            end
            MODE_REMOVE:
            begin
                if (held)
                begin
                    for (int i = pos; i + 1 < held_count; i++)
                        held_keys[i] = held_keys[i + 1];
                    held_count--;
                end
                else
                    r.status = ST_MISS;
                expected_results.push_back(r);
            end
            default:
            begin
                if (held)
                    r.found = 1'b1;
                else
                    r.status = ST_MISS;
                expected_results.push_back(r);
            end
        endcase
    endtask

    // Append one word to the driver queue.
    task automatic add_word(input mode_e m, input key_t k, input bit drain = 1'b0);
        cmd_word_t w;
        w.mode        = m;
        w.key         = k;
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d result words outstanding", expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Monitor: check result words, then predict for the accepted input word.
    always @(posedge clk)
    begin : monitor
        res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result word status=%0d key_out=%0d",
                                              status, key_out));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (found !== want.found)
                        report_mismatch($sformatf("found %0d, expected %0d", found, want.found));
                    if (key_out !== want.key_out)
                        report_mismatch($sformatf("key_out %0d, expected %0d",
                                                  key_out, want.key_out));
                    if (set_empty !== want.set_empty)
                        report_mismatch($sformatf("set_empty %0d, expected %0d",
                                                  set_empty, want.set_empty));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
                end
            end
            if (in_valid && in_ready)
            begin
                apply_word(mode_e'(mode), key);
                words_taken++;
            end
        end
    end

    // Driver: present queued input words and the receiver's ready at the falling edge.
    always @(negedge clk)
    begin : driver
        int phase;
        int send_idle;
        int recv_idle;
        phase = (total_words == 0) ? 2 : (words_sent * 3) / total_words;
        case (phase)
            0:       begin send_idle = 17; recv_idle = 59; end
            1:       begin send_idle = 59; recv_idle = 17; end
            default: begin send_idle = 0;  recv_idle = 0;  end
        endcase
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= recv_idle);
            // A new word may go out once the bus is free or the last word was taken.
            if (!in_valid || words_taken == words_sent)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle &&
                    (!pending_words[0].drain_first ||
                     (words_taken == words_sent && expected_results.size() == 0)))
                begin
                    in_valid <= 1'b1;
                    mode     <= pending_words[0].mode;
                    key      <= pending_words[0].key;
                    void'(pending_words.pop_front());
                    words_sent++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        int   n;
        int   j;
        int   roll;
        bit   dup;
        key_t cand;
        key_t tmp;
        mode_e m;

        // Directed words: empty set, extremes, duplicates, absent keys, every mode.
        add_word(MODE_LIST,   32'sd0);
        add_word(MODE_SEARCH, 32'sd0);
        add_word(MODE_REMOVE, 32'sd5);
        add_word(MODE_INSERT, 32'sd0);
        add_word(MODE_INSERT, 32'sh7FFF_FFFF);
        add_word(MODE_INSERT, 32'sh8000_0000);
        add_word(MODE_INSERT, -32'sd1);
        add_word(MODE_INSERT, 32'sd1);
        add_word(MODE_INSERT, 32'sd0);
        add_word(MODE_SEARCH, 32'sh8000_0000);
        add_word(MODE_SEARCH, 32'sh7FFF_FFFF);
        add_word(MODE_SEARCH, 32'sd2);
        add_word(MODE_LIST,   32'sd0);
        add_word(MODE_REMOVE, 32'sh8000_0000);
        add_word(MODE_REMOVE, 32'sh7FFF_FFFF);
        add_word(MODE_REMOVE, 32'sd0);
        add_word(MODE_REMOVE, 32'sd0);
        add_word(MODE_LIST,   32'sd0);
        add_word(MODE_REMOVE, -32'sd1);
        add_word(MODE_REMOVE, 32'sd1);
        add_word(MODE_LIST,   32'sh5A5A_A5A5);
        add_word(MODE_INSERT, 32'sh5555_5555);
        add_word(MODE_INSERT, 32'shAAAA_AAAA);
        add_word(MODE_SEARCH, 32'shAAAA_AAAA);

        // Key pool: extremes and their neighbors, then distinct random keys.
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        key_pool[5] = 32'sh8000_0001;
        key_pool[6] = 32'sh7FFF_FFFE;
        n = 7;
        while (n < POOL_SIZE)
        begin
            cand = key_t'($urandom());
            dup  = (cand == 32'sh5555_5555) || (cand == 32'shAAAA_AAAA);
            for (int i = 0; i < n; i++)
                if (key_pool[i] == cand)
                    dup = 1'b1;
            if (!dup)
            begin
                key_pool[n] = cand;
                n++;
            end
        end
        for (int i = POOL_SIZE - 1; i > 0; i--)
        begin
            j           = $urandom_range(i);
            tmp         = key_pool[i];
            key_pool[i] = key_pool[j];
            key_pool[j] = tmp;
        end

        // Fill past capacity, hit a duplicate while full, list the full set.
        for (int i = 0; i < POOL_SIZE - 4; i++)
            add_word(MODE_INSERT, key_pool[i], i == 0);
        add_word(MODE_INSERT, key_pool[3]);
        add_word(MODE_LIST, key_t'($urandom()));
        for (int i = 0; i < 20; i++)
            add_word(MODE_REMOVE, key_pool[$urandom_range(POOL_SIZE - 1)]);
        add_word(MODE_LIST, key_t'($urandom()));

        // Mixed random words, mostly on pool keys so that hits are common.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                m = MODE_INSERT;
            else if (roll < 65)
                m = MODE_REMOVE;
            else if (roll < 90)
                m = MODE_SEARCH;
            else
                m = MODE_LIST;
            if ($urandom_range(99) < 70)
                add_word(m, key_pool[$urandom_range(POOL_SIZE - 1)], i == 0);
            else
                add_word(m, key_t'($urandom()), i == 0);
        end
        total_words = pending_words.size();

        // Reset, released away from any clock edge.
        repeat (2) @(posedge clk);
        #1 rst_n = 1'b1;

        while (words_taken != total_words || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/skset_pkg.sv
rtl/skset_ram.sv
rtl/skset_obuf.sv
rtl/sorted_key_set.sv
dv/tb_top.sv
